// ----- rtl/core/permission_mode_string_parser_assert.svh -----
`ifndef PERMISSION_MODE_STRING_PARSER_ASSERT_SVH
`define PERMISSION_MODE_STRING_PARSER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PMSP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PMSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/pmsp_pkg.sv -----
package pmsp_pkg;

    typedef enum logic [3:0] {
        PH_FIRST      = 4'd0,
        PH_FORM       = 4'd1,
        PH_OCTAL      = 4'd2,
        PH_WHO        = 4'd3,
        PH_AFTER_OP   = 4'd4,
        PH_AFTER_COPY = 4'd5,
        PH_PERMS      = 4'd6
    } phase_t;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_ADD  = 2'd1,
        OP_DEL  = 2'd2,
        OP_SET  = 2'd3
    } op_t;

    localparam logic [1:0] KIND_EQUAL = 2'd0;
    localparam logic [1:0] KIND_ANY   = 2'd1;
    localparam logic [1:0] KIND_ALL   = 2'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_EMPTY   = 2'd1;
    localparam logic [1:0] STATUS_INVALID = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_8     = 8'h38;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_W     = 8'h77;
    localparam logic [7:0] CH_X     = 8'h78;

    localparam logic [12:0] OCT_LIMIT = 13'o7777;
    localparam logic [12:0] OCT_SAT   = 13'o10000;

    localparam logic [11:0] BIT_SUID   = 12'o4000;
    localparam logic [11:0] BIT_SGID   = 12'o2000;
    localparam logic [11:0] BIT_STICKY = 12'o1000;
    localparam logic [11:0] ALL_EXEC   = 12'o0111;

endpackage

// ----- rtl/core/permission_mode_string_parser.sv -----
// A result appears on m_tvalid from the result register once its zero byte has passed the
// input register and been decoded. The parser takes one character per cycle while the input
// register does not stall; every character is decoded between the input register and the result register.
// The input register stalls only when a zero byte meets a result that is still waiting.
// Reset (rst_n low, asynchronous) empties both registers and returns the parser to the
// state that expects the first character of a new argument.
`include "permission_mode_string_parser_assert.svh"

module permission_mode_string_parser
    import pmsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [11:0] mode_bits, [13:12] compare_kind, [15:14] status
);

    logic        in_valid_reg;
    logic [7:0]  in_char_reg;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_data_reg, out_data_next;

    phase_t      phase_reg, phase_next;
    logic [11:0] mode_reg, mode_next;
    logic [12:0] octal_reg, octal_next;
    logic [11:0] perm_reg, perm_next;
    logic [3:0]  who_reg, who_next;
    op_t         op_reg, op_next;
    logic [1:0]  kind_reg, kind_next;
    logic        err_reg, err_next;

    logic        proc_en;
    logic        end_char;
    logic [7:0]  c;
    logic        do_form, do_who, do_perm, bad;
    logic [15:0] oct_calc;
    logic [2:0]  copy_trio;
    logic [11:0] copy_perm;
    logic [1:0]  end_status;
    logic [11:0] end_mode;
    logic        named;

    // who bits: [0] u, [1] g, [2] o, [3] a
    function automatic logic [11:0] spread(input logic [3:0] who, input logic [2:0] trio);
        logic [11:0] p;
        begin
            p = '0;
            if (who[0])
                p = p | {3'b000, trio, 6'b000000};
            if (who[1])
                p = p | {6'b000000, trio, 3'b000};
            if (who[2])
                p = p | {9'b000000000, trio};
            return p;
        end
    endfunction

    function automatic logic [11:0] apply_clause(input logic [11:0] mode, input op_t op,
                                                  input logic [11:0] perm);
        logic [11:0] m;
        begin
            case (op)
                OP_DEL:  m = mode & ~perm;
                OP_ADD:  m = mode | perm;
                OP_SET:  m = (perm != 12'd0) ? perm : mode;
                default: m = mode;
            endcase
            return m;
        end
    endfunction

    assign c        = in_char_reg;
    assign end_char = (in_char_reg == CH_NUL);
    assign proc_en  = in_valid_reg && (!end_char || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || proc_en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign named    = |who_reg[2:0];
    assign oct_calc = {octal_reg, 3'b000} + {13'd0, c[2:0]};

    always_comb
    begin
        case (c)
            CH_U:    copy_trio = mode_reg[8:6];
            CH_G:    copy_trio = mode_reg[5:3];
            default: copy_trio = mode_reg[2:0];
        endcase
    end

    assign copy_perm = perm_reg | spread(who_reg, copy_trio);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_char_reg <= s_tdata;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        mode_next      = mode_reg;
        octal_next     = octal_reg;
        perm_next      = perm_reg;
        who_next       = who_reg;
        op_next        = op_reg;
        kind_next      = kind_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        do_form        = 1'b0;
        do_who         = 1'b0;
        do_perm        = 1'b0;
        bad            = 1'b0;
        end_status     = STATUS_OK;
        end_mode       = 12'd0;

        if (proc_en && end_char)
        begin
            if (phase_reg == PH_FIRST && !err_reg)
            begin
                end_status = STATUS_EMPTY;
            end
            else if (err_reg)
            begin
                end_status = STATUS_INVALID;
            end
            else if (phase_reg == PH_OCTAL)
            begin
                if (octal_reg > OCT_LIMIT)
                    end_status = STATUS_INVALID;
                else
                    end_mode = octal_reg[11:0];
            end
            else if (phase_reg == PH_FORM || phase_reg == PH_WHO)
            begin
                end_status = STATUS_INVALID;
            end
            else
            begin
                end_mode = apply_clause(mode_reg, op_reg, perm_reg);
            end
            out_valid_next = 1'b1;
            out_data_next  = {end_status, kind_reg,
                              (end_status == STATUS_OK) ? end_mode : 12'd0};
            phase_next     = PH_FIRST;
            mode_next      = '0;
            octal_next     = '0;
            perm_next      = '0;
            who_next       = '0;
            op_next        = OP_NONE;
            kind_next      = KIND_EQUAL;
            err_next       = 1'b0;
        end
        else if (proc_en && !err_reg)
        begin
            case (phase_reg)
                PH_FIRST:
                begin
                    if (c == CH_SLASH)
                    begin
                        kind_next  = KIND_ANY;
                        phase_next = PH_FORM;
                    end
                    else if (c == CH_MINUS)
                    begin
                        kind_next  = KIND_ALL;
                        phase_next = PH_FORM;
                    end
                    else
                    begin
                        do_form = 1'b1;
                    end
                end
                PH_FORM:
                begin
                    do_form = 1'b1;
                end
                PH_OCTAL:
                begin
                    if (c >= CH_0 && c <= CH_7)
                        octal_next = (oct_calc > {3'b000, OCT_SAT}) ? OCT_SAT : oct_calc[12:0];
                    else
                        bad = 1'b1;
                end
                PH_WHO:
                begin
                    do_who = 1'b1;
                end
                PH_AFTER_OP:
                begin
                    if (c == CH_U || c == CH_G || c == CH_O)
                    begin
                        perm_next  = copy_perm;
                        phase_next = (copy_perm != 12'd0) ? PH_AFTER_COPY : PH_PERMS;
                    end
                    else
                    begin
                        phase_next = PH_PERMS;
                        do_perm    = 1'b1;
                    end
                end
                PH_AFTER_COPY:
                begin
                    if (c == CH_COMMA)
                        do_perm = 1'b1;
                    else
                        bad = 1'b1;
                end
                PH_PERMS:
                begin
                    do_perm = 1'b1;
                end
                default:
                begin
                    bad = 1'b1;
                end
            endcase

            // The form character: an octal digit opens a number, else a symbolic clause.
            if (do_form)
            begin
                if (c >= CH_0 && c <= CH_7)
                begin
                    octal_next = {10'd0, c[2:0]};
                    phase_next = PH_OCTAL;
                end
                else if (c == CH_8 || c == CH_9)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    phase_next = PH_WHO;
                    do_who     = 1'b1;
                end
            end

            if (do_who)
            begin
                case (c)
                    CH_U:  who_next = who_reg | 4'b0001;
                    CH_G:  who_next = who_reg | 4'b0010;
                    CH_O:  who_next = who_reg | 4'b0100;
                    CH_A:  who_next = 4'b1111;
                    CH_PLUS:
                    begin
                        op_next    = OP_ADD;
                        phase_next = PH_AFTER_OP;
                    end
                    CH_MINUS:
                    begin
                        op_next    = OP_DEL;
                        phase_next = PH_AFTER_OP;
                    end
                    CH_EQ:
                    begin
                        op_next    = OP_SET;
                        phase_next = PH_AFTER_OP;
                    end
                    default: bad = 1'b1;
                endcase
            end

            if (do_perm)
            begin
                case (c)
                    CH_R:
                        perm_next = perm_reg | (named ? spread(who_reg, 3'b100) : 12'o0444);
                    CH_W:
                        perm_next = perm_reg | (named ? spread(who_reg, 3'b010) : 12'o0222);
                    CH_X:
                        perm_next = perm_reg | (named ? spread(who_reg, 3'b001) : 12'o0111);
                    CH_UP_X:
                    begin
                        if ((mode_reg & ALL_EXEC) != 12'd0)
                            perm_next = perm_reg | spread(who_reg, 3'b001);
                    end
                    CH_S:
                    begin
                        // Naming only the other class leaves the clause untouched.
                        perm_next = perm_reg | (who_reg[0] ? BIT_SUID : 12'd0)
                                             | (who_reg[1] ? BIT_SGID : 12'd0);
                    end
                    CH_T:
                    begin
                        if (!named || who_reg[3])
                            perm_next = perm_reg | BIT_STICKY;
                    end
                    CH_COMMA:
                    begin
                        mode_next  = apply_clause(mode_reg, op_reg, perm_reg);
                        perm_next  = '0;
                        who_next   = '0;
                        op_next    = OP_NONE;
                        phase_next = PH_WHO;
                    end
                    default: bad = 1'b1;
                endcase
            end

            if (bad)
                err_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIRST;
            mode_reg      <= '0;
            octal_reg     <= '0;
            perm_reg      <= '0;
            who_reg       <= '0;
            op_reg        <= OP_NONE;
            kind_reg      <= KIND_EQUAL;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            mode_reg      <= mode_next;
            octal_reg     <= octal_next;
            perm_reg      <= perm_next;
            who_reg       <= who_next;
            op_reg        <= op_next;
            kind_reg      <= kind_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    `PMSP_ASSERT_NOW(a_mode_zero_on_fail, out_valid_reg && out_data_reg[15:14] != STATUS_OK, out_data_reg[11:0] == 12'd0, "mode bits not zero on a failed parse")
    `PMSP_ASSERT_NEXT(a_err_sticky, err_reg && !(proc_en && end_char), err_reg, "error flag dropped before the end of the argument")
    `PMSP_ASSERT_NEXT(a_end_resets, proc_en && end_char, phase_reg == PH_FIRST && !err_reg && out_valid_reg, "end of argument did not emit a result and restart")
    `PMSP_ASSERT_NOW(a_octal_sat, 1'b1, octal_reg <= OCT_SAT, "octal accumulator above its saturation value")

endmodule

// ----- verif/mode_parse_checker.sv -----
module mode_parse_checker
    import pmsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [11:0] mode_bits, [13:12] compare_kind, [15:14] status
    output int          fail_count,
    output int          results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  kind;
        logic [11:0] mode;
    } parse_result_t;

    localparam logic [3:0] WHO_U = 4'b0001;
    localparam logic [3:0] WHO_G = 4'b0010;
    localparam logic [3:0] WHO_O = 4'b0100;
    localparam logic [3:0] WHO_A = 4'b1000;
    localparam logic [3:0] WHO_CLASSES = WHO_U | WHO_G | WHO_O;

    parse_result_t expected_results[$];
    int            mismatches = 0;
    int            owed = 0;

    // Shadow copy of the parser state.
    phase_t        parse_state;
    logic [11:0]   mode_acc;
    int unsigned   octal_acc;
    logic [11:0]   clause_bits;
    logic [3:0]    who_set;
    op_t           clause_op;
    logic [1:0]    kind_seen;
    logic          err_seen;

    assign fail_count   = mismatches;
    assign results_owed = owed;

    task automatic open_clause();
        clause_bits = '0;
        who_set     = '0;
        clause_op   = OP_NONE;
    endtask

    task automatic restart_parse();
        parse_state = PH_FIRST;
        mode_acc    = '0;
        octal_acc   = 0;
        kind_seen   = KIND_EQUAL;
        err_seen    = 1'b0;
        open_clause();
    endtask

    task automatic fold_clause();
        case (clause_op)
            OP_DEL: mode_acc &= ~clause_bits;
            OP_ADD: mode_acc |= clause_bits;
            OP_SET:
            begin
                if (clause_bits != '0)
                    mode_acc = clause_bits;
            end
            default: ;
        endcase
        open_clause();
    endtask

    // Places one permission trio into every class named in the clause.
    function automatic logic [11:0] widen(input logic [2:0] trio);
        logic [11:0] bits;
        bits = '0;
        if (who_set[0])
            bits |= {3'b000, trio, 6'b000000};
        if (who_set[1])
            bits |= {6'b000000, trio, 3'b000};
        if (who_set[2])
            bits |= {9'b000000000, trio};
        return bits;
    endfunction

    task automatic perm_letter(input logic [7:0] c, output logic ok);
        logic       named;
        logic [2:0] trio;
        named = (who_set & WHO_CLASSES) != '0;
        ok    = 1'b1;
        case (c)
            CH_R, CH_W, CH_X:
            begin
                trio = (c == CH_R) ? 3'd4 : (c == CH_W) ? 3'd2 : 3'd1;
                clause_bits |= named ? widen(trio) : {3'b000, trio, trio, trio};
            end
            CH_UP_X:
            begin
                if ((mode_acc & ALL_EXEC) != '0)
                    clause_bits |= widen(3'd1);
            end
            CH_S:
            begin
                // With only the other class named, setuid and setgid do not apply.
                if ((who_set & WHO_CLASSES) != WHO_O)
                begin
                    if (who_set[0])
                        clause_bits |= BIT_SUID;
                    if (who_set[1])
                        clause_bits |= BIT_SGID;
                end
            end
            CH_T:
            begin
                if (!named || who_set[3])
                    clause_bits |= BIT_STICKY;
            end
            CH_COMMA:
            begin
                fold_clause();
                parse_state = PH_WHO;
            end
            default: ok = 1'b0;
        endcase
    endtask

    task automatic who_letter(input logic [7:0] c, output logic ok);
        ok = 1'b1;
        case (c)
            CH_U:     who_set |= WHO_U;
            CH_G:     who_set |= WHO_G;
            CH_O:     who_set |= WHO_O;
            CH_A:     who_set |= WHO_CLASSES | WHO_A;
            CH_PLUS:
            begin
                clause_op   = OP_ADD;
                parse_state = PH_AFTER_OP;
            end
            CH_MINUS:
            begin
                clause_op   = OP_DEL;
                parse_state = PH_AFTER_OP;
            end
            CH_EQ:
            begin
                clause_op   = OP_SET;
                parse_state = PH_AFTER_OP;
            end
            default: ok = 1'b0;
        endcase
    endtask

    task automatic form_letter(input logic [7:0] c, output logic ok);
        ok = 1'b1;
        if (c >= CH_0 && c <= CH_7)
        begin
            octal_acc   = c - CH_0;
            parse_state = PH_OCTAL;
        end
        else if (c == CH_8 || c == CH_9)
            ok = 1'b0;
        else
        begin
            parse_state = PH_WHO;
            who_letter(c, ok);
        end
    endtask

    task automatic take_char(input logic [7:0] c);
        logic          ok;
        logic [2:0]    trio;
        parse_result_t res;
        ok = 1'b1;
        if (c == CH_NUL)
        begin
            res.status = STATUS_OK;
            res.kind   = kind_seen;
            res.mode   = '0;
            if (parse_state == PH_FIRST && !err_seen)
                res.status = STATUS_EMPTY;
            else if (err_seen)
                res.status = STATUS_INVALID;
            else if (parse_state == PH_OCTAL)
            begin
                if (octal_acc > OCT_LIMIT)
                    res.status = STATUS_INVALID;
                else
                    res.mode = octal_acc[11:0];
            end
            else if (parse_state == PH_FORM || parse_state == PH_WHO)
                res.status = STATUS_INVALID;
            else
            begin
                fold_clause();
                res.mode = mode_acc;
            end
            expected_results.push_back(res);
            restart_parse();
        end
        else if (!err_seen)
        begin
            case (parse_state)
                PH_FIRST:
                begin
                    if (c == CH_SLASH)
                    begin
                        kind_seen   = KIND_ANY;
                        parse_state = PH_FORM;
                    end
                    else if (c == CH_MINUS)
                    begin
                        kind_seen   = KIND_ALL;
                        parse_state = PH_FORM;
                    end
                    else
                        form_letter(c, ok);
                end
                PH_FORM: form_letter(c, ok);
                PH_OCTAL:
                begin
                    if (c >= CH_0 && c <= CH_7)
                    begin
                        octal_acc = octal_acc * 8 + (c - CH_0);
                        if (octal_acc > OCT_SAT)
                            octal_acc = OCT_SAT;
                    end
                    else
                        ok = 1'b0;
                end
                PH_WHO: who_letter(c, ok);
                PH_AFTER_OP:
                begin
                    if (c == CH_U || c == CH_G || c == CH_O)
                    begin
                        // The copy reads the mode as it stood before this clause.
                        trio = (c == CH_U) ? mode_acc[8:6] :
                               (c == CH_G) ? mode_acc[5:3] : mode_acc[2:0];
                        clause_bits |= widen(trio);
                        parse_state = (clause_bits != '0) ? PH_AFTER_COPY : PH_PERMS;
                    end
                    else
                    begin
                        parse_state = PH_PERMS;
                        perm_letter(c, ok);
                    end
                end
                PH_AFTER_COPY:
                begin
                    if (c == CH_COMMA)
                        perm_letter(c, ok);
                    else
                        ok = 1'b0;
                end
                PH_PERMS: perm_letter(c, ok);
                default: ok = 1'b0;
            endcase
            if (!ok)
                err_seen = 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        parse_result_t want;
        parse_result_t got;
        if (!rst_n)
        begin
            restart_parse();
            expected_results.delete();
            owed = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                take_char(s_tdata);
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result transfer with none expected: status %0d kind %0d mode %o",
                             $time, got.status, got.kind, got.mode);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.mode !== want.mode)
                    begin
                        mismatches++;
                        $display("%0t: mode_bits expected %o actual %o",
                                 $time, want.mode, got.mode);
                    end
                    if (got.kind !== want.kind)
                    begin
                        mismatches++;
                        $display("%0t: compare_kind expected %0d actual %0d",
                                 $time, want.kind, got.kind);
                    end
                    if (got.status !== want.status)
                    begin
                        mismatches++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                    end
                end
            end
            owed = expected_results.size();
        end
    end

endmodule

// ----- verif/tb.sv -----
module tb;
    import pmsp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 150000;
    localparam int PHASE_CHARS  = 285;
    localparam int HOLD_CYCLES  = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    int          fail_count;
    int          results_owed;
    int          cycle_count = 0;
    int          chars_sent = 0;
    int          sender_idle_pct = 0;
    int          stall_pct = 0;
    logic        hold_go = 1'b0;
    logic        hold_active = 1'b0;
    logic [7:0]  arg_chars[$];

    permission_mode_string_parser dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    mode_parse_checker checker_i
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL permission_mode_string_parser");
            $finish;
        end
    end

    always @(negedge clk)
        m_tready <= hold_active ? 1'b0 : ($urandom_range(99) >= stall_pct);

    // Long receiver hold-off so that results back up and the input stalls.
    initial
    begin
        @(posedge hold_go);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_active <= 1'b0;
    end

    function automatic logic [7:0] random_char();
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic logic [7:0] pick(input string letters);
        return letters[$urandom_range(letters.len() - 1)];
    endfunction

    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        chars_sent++;
    endtask

    task automatic send_argument();
        foreach (arg_chars[i])
            send_char(arg_chars[i]);
        send_char(CH_NUL);
    endtask

    task automatic send_text(input string text);
        arg_chars.delete();
        for (int i = 0; i < text.len(); i++)
            arg_chars.push_back(text[i]);
        send_argument();
    endtask

    // Mostly well-formed octal and symbolic arguments, with some broken ones and noise.
    task automatic build_argument();
        int form_roll;
        int digits;
        int clauses;
        arg_chars.delete();
        case ($urandom_range(3))
            2: arg_chars.push_back(CH_SLASH);
            3: arg_chars.push_back(CH_MINUS);
            default: ;
        endcase
        form_roll = $urandom_range(99);
        if (form_roll < 35)
        begin
            digits = ($urandom_range(7) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
            repeat (digits)
                arg_chars.push_back(CH_0 + 8'($urandom_range(7)));
            if ($urandom_range(9) == 0)
                arg_chars[$urandom_range(arg_chars.size() - 1)] = random_char();
        end
        else if (form_roll < 85)
        begin
            clauses = $urandom_range(1, 3);
            for (int k = 0; k < clauses; k++)
            begin
                if (k > 0)
                    arg_chars.push_back(CH_COMMA);
                repeat ($urandom_range(3))
                    arg_chars.push_back(pick("ugoa"));
                if ($urandom_range(15) != 0)
                    arg_chars.push_back(pick("+-="));
                if ($urandom_range(3) == 0)
                begin
                    arg_chars.push_back(pick("ugo"));
                    if ($urandom_range(2) == 0)
                        arg_chars.push_back(pick("rwxXst"));
                end
                else
                begin
                    repeat ($urandom_range(4))
                        arg_chars.push_back(pick("rwxXst"));
                end
            end
            if ($urandom_range(11) == 0)
                arg_chars.push_back(CH_COMMA);
            if ($urandom_range(11) == 0)
                arg_chars.insert($urandom_range(arg_chars.size()), random_char());
        end
        else if (form_roll < 93)
        begin
            repeat ($urandom_range(6))
                arg_chars.push_back(random_char());
        end
    endtask

    initial
    begin
        int phase_start;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_text("");
        send_text("/");
        send_text("9");
        send_text("-17777");
        send_text("a=rwXst");
        send_text("+!");

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct = 0;
                    stall_pct <= 0;
                end
                1:
                begin
                    sender_idle_pct = 68;
                    stall_pct <= 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    stall_pct <= 68;
                end
                default:
                begin
                    sender_idle_pct = 33;
                    stall_pct <= 33;
                end
            endcase
            phase_start = chars_sent;
            while (chars_sent - phase_start < PHASE_CHARS)
            begin
                if (phase == 0 && chars_sent - phase_start > 40)
                    hold_go <= 1'b1;
                build_argument();
                send_argument();
            end
        end
        s_tvalid <= 1'b0;

        wait (results_owed == 0);
        repeat (8) @(posedge clk);
        if (fail_count == 0 && results_owed == 0)
            $display("PASS permission_mode_string_parser");
        else
            $display("FAIL permission_mode_string_parser");
        $finish;
    end

endmodule

// ----- permission_mode_string_parser.f -----
+incdir+rtl/core
rtl/core/pmsp_pkg.sv
rtl/core/permission_mode_string_parser.sv
verif/mode_parse_checker.sv
verif/tb.sv
